// File: hw/rtl/weighted_pose_window_filter_core_macros.svh
// Assertion macros for the pose window filter
`ifndef WEIGHTED_POSE_WINDOW_FILTER_CORE_MACROS_SVH
`define WEIGHTED_POSE_WINDOW_FILTER_CORE_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define WPWF_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// Check that a condition implies a consequence in the next cycle
`define WPWF_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`endif

// File: hw/rtl/wpwf_pkg.sv
package wpwf_pkg;
   localparam int MAX_WINDOW = 8;
   localparam int CordicSteps = 20;
   localparam logic [31:0] CordicGain = 32'd652032874;
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic        start;
      logic [31:0] phase;
   } cordic_req_type;

   // Phase of atan(2^-i), 2^32 per turn
   function automatic logic [31:0] atan_phase(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         default: r = 32'd0;
      endcase
      return r;
   endfunction
endpackage

// File: hw/rtl/weighted_pose_window_filter_core.sv
// Per window entry: one read, three sine/cosine passes and three accumulate steps;
// then three atan2 passes, three divides and one output state before result valid.
// One item at a time; a clear is done in the idle state, with no walk of the
// window.
// Reset (synchronous, active high) sets window size 4 and empties the window.
module weighted_pose_window_filter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_roll_in,
   input  logic signed [15:0] req_pitch_in,
   input  logic signed [15:0] req_yaw_in,
   input  logic signed [31:0] req_base_x_in,
   input  logic signed [31:0] req_base_y_in,
   input  logic signed [31:0] req_base_z_in,
   input  logic               csr_write_enable,
   input  logic [3:0]         csr_write_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_mean_x,
   output logic signed [31:0] rsp_mean_y,
   output logic signed [31:0] rsp_mean_z,
   output logic signed [15:0] rsp_mean_roll,
   output logic signed [15:0] rsp_mean_pitch,
   output logic signed [15:0] rsp_mean_yaw,
   output logic signed [31:0] rsp_base_x_out,
   output logic signed [31:0] rsp_base_y_out,
   output logic signed [31:0] rsp_base_z_out
);
   import wpwf_pkg::*;
   `include "weighted_pose_window_filter_core_macros.svh"

   localparam int SlotW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CntW  = $clog2(MAX_WINDOW + 1);
   localparam int WsumW = 10 + $clog2(MAX_WINDOW + 1);
   localparam int WtW   = $clog2(2 * MAX_WINDOW + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_READ  = 4'd1;
   localparam logic [3:0] ST_SC    = 4'd2;
   localparam logic [3:0] ST_SCW   = 4'd3;
   localparam logic [3:0] ST_ACC   = 4'd4;
   localparam logic [3:0] ST_AT    = 4'd5;
   localparam logic [3:0] ST_ATW   = 4'd6;
   localparam logic [3:0] ST_DV    = 4'd7;
   localparam logic [3:0] ST_DVW   = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   // History memory: 96 bits position and 48 bits angle per entry
   logic [143:0] hist_mem [MAX_WINDOW];
   logic [143:0] rd_data_ff;
   logic         wr_en;
   logic [SlotW-1:0] wr_addr, rd_addr;
   logic [143:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) hist_mem[wr_addr] <= wr_data;
      rd_data_ff <= hist_mem[rd_addr];
   end

   logic [3:0]        state_ff, state_in;
   logic [CntW-1:0]   wsize_ff, wsize_in, fill_ff, fill_in, idx_ff, idx_in;
   logic [SlotW-1:0]  oldest_ff, oldest_in;
   logic [1:0]        ang_ff, ang_in;
   logic [WsumW-1:0]  wsum_ff, wsum_in;
   logic signed [63:0] acc_p_ff [3], acc_p_in [3];
   logic signed [63:0] acc_s_ff [3], acc_s_in [3];
   logic signed [63:0] acc_c_ff [3], acc_c_in [3];
   logic [15:0]       mean_ang_ff [3], mean_ang_in [3];
   logic [31:0]       mean_p_ff [3], mean_p_in [3];
   logic [31:0]       base_ff [3], base_in [3];
   logic [WtW-1:0]    wt;
   logic              out_valid_ff, out_valid_in;
   cordic_req_type    sc_req;
   logic              sc_done, at_start, at_done, dv_start, dv_done;
   logic signed [31:0] sc_cos, sc_sin;
   logic [15:0]       at_angle;
   logic [31:0]       dv_q;
   logic [15:0]       ang_sel;
   logic signed [63:0] at_s, at_c, dv_num;
   logic [3:0]        cfg_sat;
   logic              req_take;

   assign req_stall = (state_ff != ST_IDLE) || out_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign cfg_sat = (csr_write_data == 4'd0) ? 4'd1 :
                    ((32'(csr_write_data) > MAX_WINDOW) ? 4'(MAX_WINDOW) : csr_write_data);

   // Weight of the entry under walk
   assign wt = (fill_ff == wsize_ff && idx_ff == fill_ff - 1'b1) ?
               WtW'({wsize_ff, 1'b0}) : WtW'(idx_ff + 1'b1);

   always_comb begin
      case (ang_ff)
         2'd0:    ang_sel = rd_data_ff[111:96];
         2'd1:    ang_sel = rd_data_ff[127:112];
         default: ang_sel = rd_data_ff[143:128];
      endcase
   end
   assign sc_req.start = (state_ff == ST_SC);
   assign sc_req.phase = {ang_sel, 16'h0};
   assign at_start = (state_ff == ST_AT);
   assign at_s = acc_s_ff[ang_ff];
   assign at_c = acc_c_ff[ang_ff];
   assign dv_start = (state_ff == ST_DV);
   assign dv_num = acc_p_ff[ang_ff];

   wpwf_sincos u_sincos (.clock, .reset, .req(sc_req), .done(sc_done),
      .cos_out(sc_cos), .sin_out(sc_sin));
   wpwf_atan2 u_atan2 (.clock, .reset, .start(at_start), .sum_s(at_s), .sum_c(at_c),
      .done(at_done), .angle(at_angle));
   wpwf_divider u_div (.clock, .reset, .start(dv_start), .dividend(dv_num),
      .divisor(10'(wsum_ff)), .done(dv_done), .quotient(dv_q));

   always_comb begin
      state_in = state_ff;
      wsize_in = wsize_ff;
      fill_in = fill_ff;
      oldest_in = oldest_ff;
      idx_in = idx_ff;
      ang_in = ang_ff;
      wsum_in = wsum_ff;
      acc_p_in = acc_p_ff;
      acc_s_in = acc_s_ff;
      acc_c_in = acc_c_ff;
      mean_ang_in = mean_ang_ff;
      mean_p_in = mean_p_ff;
      base_in = base_ff;
      out_valid_in = out_valid_ff;
      wr_en = 1'b0;
      wr_addr = SlotW'((CntW'(oldest_ff) + fill_ff) % MAX_WINDOW);
      wr_data = {req_yaw_in, req_pitch_in, req_roll_in, req_pos_z, req_pos_y, req_pos_x};
      rd_addr = SlotW'((CntW'(oldest_ff) + idx_ff) % MAX_WINDOW);
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_write_enable) begin
               wsize_in = CntW'(cfg_sat);
               fill_in = '0;
               oldest_in = '0;
            end else if (req_take) begin
               if (req_opcode == OP_CLEAR) begin
                  fill_in = '0;
                  oldest_in = '0;
               end else begin
                  // drop the oldest entry of a full window, then store
                  if (fill_ff >= wsize_ff) begin
                     oldest_in = SlotW'((CntW'(oldest_ff) + 1'b1) % MAX_WINDOW);
                     wr_addr = SlotW'((CntW'(oldest_in) + wsize_ff - 1'b1) % MAX_WINDOW);
                     fill_in = wsize_ff;
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
                  wr_en = 1'b1;
                  base_in[0] = req_base_x_in;
                  base_in[1] = req_base_y_in;
                  base_in[2] = req_base_z_in;
                  idx_in = '0;
                  wsum_in = '0;
                  for (int k = 0; k < 3; k++) begin
                     acc_p_in[k] = '0;
                     acc_s_in[k] = '0;
                     acc_c_in[k] = '0;
                  end
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ang_in = '0;
            state_in = ST_SC;
         end
         ST_SC: state_in = ST_SCW;
         ST_SCW: begin
            if (sc_done) begin
               acc_s_in[ang_ff] = acc_s_ff[ang_ff] + 64'(sc_sin) * $signed({1'b0, wt});
               acc_c_in[ang_ff] = acc_c_ff[ang_ff] + 64'(sc_cos) * $signed({1'b0, wt});
               if (ang_ff == 2'd2) state_in = ST_ACC;
               else begin
                  ang_in = ang_ff + 2'd1;
                  state_in = ST_SC;
               end
            end
         end
         ST_ACC: begin
            // accumulate positions, one per cycle
            acc_p_in[ang_ff] = acc_p_ff[ang_ff] + 64'($signed(rd_data_ff[32*ang_ff +: 32]))
                               * $signed({1'b0, wt});
            if (ang_ff == 2'd0) begin
               wsum_in = wsum_ff + WsumW'(wt);
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == fill_ff) state_in = ST_AT;
               else state_in = ST_READ;
               ang_in = '0;
            end else ang_in = ang_ff - 2'd1;
            if (ang_ff == 2'd2) ang_in = 2'd1;
         end
         ST_AT: state_in = ST_ATW;
         ST_ATW: begin
            if (at_done) begin
               mean_ang_in[ang_ff] = at_angle;
               if (ang_ff == 2'd2) begin
                  ang_in = '0;
                  state_in = ST_DV;
               end else begin
                  ang_in = ang_ff + 2'd1;
                  state_in = ST_AT;
               end
            end
         end
         ST_DV: state_in = ST_DVW;
         ST_DVW: begin
            if (dv_done) begin
               mean_p_in[ang_ff] = dv_q;
               if (ang_ff == 2'd2) state_in = ST_OUT;
               else begin
                  ang_in = ang_ff + 2'd1;
                  state_in = ST_DV;
               end
            end
         end
         ST_OUT: begin
            out_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wsize_ff <= CntW'((4 > MAX_WINDOW) ? MAX_WINDOW : 4);
         fill_ff <= '0;
         oldest_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wsize_ff <= wsize_in;
         fill_ff <= fill_in;
         oldest_ff <= oldest_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff <= idx_in;
      ang_ff <= ang_in;
      wsum_ff <= wsum_in;
      acc_p_ff <= acc_p_in;
      acc_s_ff <= acc_s_in;
      acc_c_ff <= acc_c_in;
      mean_ang_ff <= mean_ang_in;
      mean_p_ff <= mean_p_in;
      base_ff <= base_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_mean_x     = mean_p_ff[0];
   assign rsp_mean_y     = mean_p_ff[1];
   assign rsp_mean_z     = mean_p_ff[2];
   assign rsp_mean_roll  = mean_ang_ff[0];
   assign rsp_mean_pitch = mean_ang_ff[1];
   assign rsp_mean_yaw   = mean_ang_ff[2];
   assign rsp_base_x_out = base_ff[0];
   assign rsp_base_y_out = base_ff[1];
   assign rsp_base_z_out = base_ff[2];

   `WPWF_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= wsize_ff, "fill over size")
   `WPWF_ASSERT_IMP(a_size_range, clock, reset, 1'b1, wsize_ff >= 1, "window size zero")
   `WPWF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_mean_x), "result dropped")
   `WPWF_ASSERT_IMP(a_walk_fill, clock, reset, state_ff != ST_IDLE, fill_ff != 0,
      "walk on empty window")
endmodule

// File: hw/rtl/wpwf_sincos.sv
// Iterative rotation CORDIC: one step per cycle
module wpwf_sincos (
   input  logic                    clock,
   input  logic                    reset,
   input  wpwf_pkg::cordic_req_type req,
   output logic                    done,
   output logic signed [31:0]      cos_out,
   output logic signed [31:0]      sin_out
);
   import wpwf_pkg::*;

   logic                busy_ff, busy_in;
   logic [4:0]          step_ff, step_in;
   logic                flip_ff, flip_in;
   logic signed [31:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                done_ff, done_in;
   logic [31:0]         ph;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      flip_in = flip_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      done_in = 1'b0;
      ph = req.phase;
      if (req.start) begin
         // fold into the right half plane
         flip_in = (ph >= 32'h4000_0000) && (ph < 32'hC000_0000);
         if (flip_in) ph = ph ^ 32'h8000_0000;
         z_in = ph;
         x_in = CordicGain;
         y_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - (y_ff >>> step_ff);
            y_in = y_ff + (x_ff >>> step_ff);
            z_in = z_ff - atan_phase(step_ff);
         end else begin
            x_in = x_ff + (y_ff >>> step_ff);
            y_in = y_ff - (x_ff >>> step_ff);
            z_in = z_ff + atan_phase(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      flip_ff <= flip_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
endmodule

// File: hw/rtl/wpwf_atan2.sv
// Iterative vectoring CORDIC on 64-bit sums: one step per cycle
module wpwf_atan2 (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] sum_s,
   input  logic signed [63:0] sum_c,
   output logic               done,
   output logic [15:0]        angle
);
   import wpwf_pkg::*;

   logic               busy_ff, busy_in, done_ff, done_in;
   logic [4:0]         step_ff, step_in;
   logic signed [64:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]        z_ff, z_in;
   logic [31:0]        ph;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      done_in = 1'b0;
      if (start) begin
         if (sum_c[63]) begin
            x_in = -{sum_c[63], sum_c};
            y_in = -{sum_s[63], sum_s};
            z_in = 32'h8000_0000;
         end else begin
            x_in = {sum_c[63], sum_c};
            y_in = {sum_s[63], sum_s};
            z_in = '0;
         end
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // zero sums end at phase zero, since y stays zero
         if (y_ff > 0) begin
            x_in = x_ff + (y_ff >>> step_ff);
            y_in = y_ff - (x_ff >>> step_ff);
            z_in = z_ff + atan_phase(step_ff);
         end else if (y_ff < 0) begin
            x_in = x_ff - (y_ff >>> step_ff);
            y_in = y_ff + (x_ff >>> step_ff);
            z_in = z_ff - atan_phase(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign ph    = z_ff + 32'h0000_8000;
   assign done  = done_ff;
   assign angle = ph[31:16];
endmodule

// File: hw/rtl/wpwf_divider.sv
// Restoring divider with round to nearest, ties away from zero
module wpwf_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [9:0]         divisor,
   output logic               done,
   output logic [31:0]        quotient
);
   logic               busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [63:0]        num_ff, num_in;
   logic [10:0]        rem_ff, rem_in;
   logic [9:0]         den_ff, den_in;
   logic [63:0]        mag;
   logic [11:0]        trial;
   logic [63:0]        qneg;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      mag = dividend[63] ? -dividend : dividend;
      trial = '0;
      if (start) begin
         // add half the divisor up front for rounding
         num_in = mag + 64'(divisor >> 1);
         den_in = divisor;
         neg_in = dividend[63];
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, num_ff[63]} - {2'b0, den_ff};
         if (!trial[11]) rem_in = trial[10:0];
         else rem_in = {rem_ff[9:0], num_ff[63]};
         num_in = {num_ff[62:0], ~trial[11]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign qneg     = -num_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? qneg[31:0] : num_ff[31:0];
endmodule
